FILE: hdl/local_history_branch_predictor_defines.svh
// Assertion macros shared by the predictor RTL.
`ifndef LOCAL_HISTORY_BRANCH_PREDICTOR_DEFINES_SVH
`define LOCAL_HISTORY_BRANCH_PREDICTOR_DEFINES_SVH

// Same-cycle implication, checked on clk, off during reset.
`define LHBP_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on clk, off during reset.
`define LHBP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/lhbp_pkg.sv
package lhbp_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int ENTRY_W     = $clog2(MAX_ENTRIES);
    localparam int COUNT_W     = ENTRY_W + 1;
    localparam int HIST_LEN    = 3;
    localparam int PATTERNS    = 1 << HIST_LEN;
    localparam int CFG_W       = 3;
    localparam int MISS_W      = 32;

    typedef logic [ENTRY_W-1:0]  entry_t;
    typedef logic [COUNT_W-1:0]  count_t;
    typedef logic [HIST_LEN-1:0] hist_t;
    typedef logic [CFG_W-1:0]    cfg_t;
    typedef logic [MISS_W-1:0]   miss_t;
    typedef logic [1:0]          ctr_t;
    typedef logic [PATTERNS-1:0][1:0] ctr_row_t;

    localparam ctr_t CTR_SN = 2'd0;
    localparam ctr_t CTR_ST = 2'd3;

    localparam cfg_t MAX_LOG2 = CFG_W'(ENTRY_W);

    typedef struct packed {
        logic   fire;
        entry_t entry;
        logic   taken;
    } lhbp_req_t;

    typedef struct packed {
        hist_t history;
        logic  pred;
        logic  miss;
        miss_t miss_total;
    } lhbp_rsp_t;

    // One saturating step of a 2-bit counter toward the outcome.
    function automatic ctr_t ctr_step(ctr_t c, logic t);
        ctr_t r;
        r = c;
        if (t)
        begin
            if (c != CTR_ST)
                r = c + 2'd1;
        end
        else
        begin
            if (c != CTR_SN)
                r = c - 2'd1;
        end
        return r;
    endfunction

endpackage

FILE: hdl/lhbp_table.sv
`include "local_history_branch_predictor_defines.svh"

module lhbp_table
    import lhbp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  lhbp_req_t req,
    output lhbp_rsp_t rsp
);

    hist_t    hist_reg [MAX_ENTRIES];
    ctr_row_t ctr_reg  [MAX_ENTRIES];
    miss_t    miss_reg [MAX_ENTRIES];

    hist_t    hist_cur;
    ctr_row_t row_cur;
    ctr_t     ctr_cur;
    miss_t    miss_cur;
    logic     pred;
    logic     miss;
    hist_t    hist_next;
    ctr_row_t row_next;
    miss_t    miss_next;

    always_comb
    begin
        hist_cur  = hist_reg[req.entry];
        row_cur   = ctr_reg[req.entry];
        miss_cur  = miss_reg[req.entry];
        ctr_cur   = row_cur[hist_cur];
        pred      = ctr_cur[1];
        miss      = pred ^ req.taken;
        hist_next = {hist_cur[HIST_LEN-2:0], req.taken};
        row_next  = row_cur;
        row_next[hist_cur] = ctr_step(ctr_cur, req.taken);
        miss_next = miss_cur;
        if (miss && (miss_cur != '1))
            miss_next = miss_cur + MISS_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_ENTRIES; i++)
            begin
                hist_reg[i] <= '0;
                ctr_reg[i]  <= '0;
                miss_reg[i] <= '0;
            end
        end
        else if (req.fire)
        begin
            hist_reg[req.entry] <= hist_next;
            ctr_reg[req.entry]  <= row_next;
            miss_reg[req.entry] <= miss_next;
        end
    end

    assign rsp.history    = hist_cur;
    assign rsp.pred       = pred;
    assign rsp.miss       = miss;
    assign rsp.miss_total = miss_next;

    `LHBP_ASSERT_NEXT(a_miss_written, req.fire,
        miss_reg[$past(req.entry)] == $past(rsp.miss_total), "miss count not stored")
    `LHBP_ASSERT_NEXT(a_hist_shift, req.fire,
        hist_reg[$past(req.entry)][0] == $past(req.taken), "outcome not shifted in")
    `LHBP_ASSERT_NEXT(a_miss_monotonic, req.fire,
        miss_reg[$past(req.entry)] >= $past(miss_cur), "miss count went down")

endmodule

FILE: hdl/local_history_branch_predictor.sv
// Local-history branch predictor, one word in and one word out per branch.
// Path: input register, then result register after the table read-modify-write.
// Throughput: 1 word per cycle unless out_stall holds back a result.
// The per-entry table update is written when the staged word moves to the result register.
// Reset (rst_n, async, active low): one entry in use, pointer at entry 0,
// all histories, counters (SN) and miss counts cleared.
`include "local_history_branch_predictor_defines.svh"

module local_history_branch_predictor
    import lhbp_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   cfg_we,
    input  cfg_t   cfg_wdata,
    input  logic   in_valid,
    output logic   in_stall,
    input  logic   taken,
    output logic   out_valid,
    input  logic   out_stall,
    output entry_t entry_used,
    output hist_t  history_used,
    output logic   predicted_taken,
    output logic   actual_taken,
    output logic   missed,
    output miss_t  miss_total
);

    cfg_t   cfg_reg;
    entry_t ptr_reg, ptr_next;
    logic   s1_valid_reg;
    entry_t s1_entry_reg;
    logic   s1_taken_reg;
    logic   out_valid_reg;
    entry_t entry_reg;
    hist_t  hist_reg;
    logic   pred_reg;
    logic   taken_reg;
    logic   miss_reg;
    miss_t  total_reg;

    cfg_t      log2_eff;
    count_t    count;
    entry_t    e_sel;
    count_t    ptr_inc;
    logic      out_load;
    logic      s1_fire;
    logic      in_fire;
    lhbp_req_t req;
    lhbp_rsp_t rsp;

    always_comb
    begin
        log2_eff = (cfg_reg > MAX_LOG2) ? MAX_LOG2 : cfg_reg;
        count    = count_t'(1) << log2_eff;
        e_sel    = ({1'b0, ptr_reg} >= count) ? '0 : ptr_reg;
        ptr_inc  = {1'b0, e_sel} + count_t'(1);
        ptr_next = (ptr_inc >= count) ? '0 : ptr_inc[ENTRY_W-1:0];
    end

    assign out_load = !out_valid_reg || !out_stall;
    assign s1_fire  = s1_valid_reg && out_load;
    assign in_stall = s1_valid_reg && !out_load;
    assign in_fire  = in_valid && !in_stall;

    assign req.fire  = s1_fire;
    assign req.entry = s1_entry_reg;
    assign req.taken = s1_taken_reg;

    lhbp_table u_table (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg       <= '0;
            ptr_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                cfg_reg <= cfg_wdata;
            if (in_fire)
                ptr_reg <= ptr_next;
            if (in_fire)
                s1_valid_reg <= 1'b1;
            else if (s1_fire)
                s1_valid_reg <= 1'b0;
            if (out_load)
                out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_entry_reg <= e_sel;
            s1_taken_reg <= taken;
        end
        if (s1_fire)
        begin
            entry_reg <= s1_entry_reg;
            hist_reg  <= rsp.history;
            pred_reg  <= rsp.pred;
            taken_reg <= s1_taken_reg;
            miss_reg  <= rsp.miss;
            total_reg <= rsp.miss_total;
        end
    end

    assign out_valid       = out_valid_reg;
    assign entry_used      = entry_reg;
    assign history_used    = hist_reg;
    assign predicted_taken = pred_reg;
    assign actual_taken    = taken_reg;
    assign missed          = miss_reg;
    assign miss_total      = total_reg;

    `LHBP_ASSERT_NEXT(a_s1_to_out, s1_fire, out_valid_reg, "staged word not delivered")
    `LHBP_ASSERT_IMPLY(a_miss_flag, out_valid_reg,
        miss_reg == (pred_reg ^ taken_reg), "miss flag inconsistent")
    `LHBP_ASSERT_IMPLY(a_miss_nonzero, out_valid_reg && miss_reg,
        total_reg != '0, "miss without count")

endmodule

FILE: tb/sv/branch_outcome_checker.sv
`timescale 1ns / 1ps

module branch_outcome_checker
    import lhbp_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   cfg_we,
    input  cfg_t   cfg_wdata,
    input  logic   in_valid,
    input  logic   in_stall,
    input  logic   taken,
    input  logic   out_valid,
    input  logic   out_stall,
    input  entry_t entry_used,
    input  hist_t  history_used,
    input  logic   predicted_taken,
    input  logic   actual_taken,
    input  logic   missed,
    input  miss_t  miss_total,
    output int     fails,
    output int     checked
);

    typedef struct packed {
        entry_t entry;
        hist_t  history;
        logic   pred;
        logic   actual;
        logic   miss;
        miss_t  total;
    } branch_word_t;

    branch_word_t predicted_words[$];

    hist_t hist_mem [MAX_ENTRIES];
    ctr_t  ctr_mem  [MAX_ENTRIES][PATTERNS];
    miss_t miss_mem [MAX_ENTRIES];
    int    next_entry;
    cfg_t  entry_log2;

    always @(posedge clk or negedge rst_n)
    begin
        branch_word_t exp_w;
        int   n_used;
        int   e;
        int   bad;
        ctr_t c;
        if (!rst_n)
        begin
            predicted_words.delete();
            foreach (hist_mem[i])
            begin
                hist_mem[i] = '0;
                miss_mem[i] = '0;
                for (int j = 0; j < PATTERNS; j++)
                    ctr_mem[i][j] = CTR_SN;
            end
            next_entry = 0;
            entry_log2 = '0;
            fails      <= 0;
            checked    <= 0;
        end
        else
        begin
            bad = 0;
            if (out_valid && !out_stall)
            begin
                if (predicted_words.size() == 0)
                begin
                    $display("%0t: result word with nothing expected, entry_used %0d",
                             $time, entry_used);
                    bad++;
                end
                else
                begin
                    exp_w = predicted_words.pop_front();
                    checked <= checked + 1;
                    if (entry_used !== exp_w.entry)
                    begin
                        $display("%0t: entry_used expected %0d actual %0d",
                                 $time, exp_w.entry, entry_used);
                        bad++;
                    end
                    if (history_used !== exp_w.history)
                    begin
                        $display("%0t: history_used expected %b actual %b",
                                 $time, exp_w.history, history_used);
                        bad++;
                    end
                    if (predicted_taken !== exp_w.pred)
                    begin
                        $display("%0t: predicted_taken expected %b actual %b",
                                 $time, exp_w.pred, predicted_taken);
                        bad++;
                    end
                    if (actual_taken !== exp_w.actual)
                    begin
                        $display("%0t: actual_taken expected %b actual %b",
                                 $time, exp_w.actual, actual_taken);
                        bad++;
                    end
                    if (missed !== exp_w.miss)
                    begin
                        $display("%0t: missed expected %b actual %b",
                                 $time, exp_w.miss, missed);
                        bad++;
                    end
                    if (miss_total !== exp_w.total)
                    begin
                        $display("%0t: miss_total expected %0d actual %0d",
                                 $time, exp_w.total, miss_total);
                        bad++;
                    end
                end
            end
            if (bad != 0)
                fails <= fails + bad;

            if (in_valid && !in_stall)
            begin
                n_used = (entry_log2 >= MAX_LOG2) ? MAX_ENTRIES : (1 << entry_log2);
                e = (next_entry >= n_used) ? 0 : next_entry;
                exp_w.entry   = entry_t'(e);
                exp_w.history = hist_mem[e];
                c = ctr_mem[e][exp_w.history];
                exp_w.pred   = c[1];
                exp_w.actual = taken;
                exp_w.miss   = c[1] ^ taken;
                if (taken)
                    c = (c == CTR_ST) ? c : c + 2'd1;
                else
                    c = (c == CTR_SN) ? c : c - 2'd1;
                ctr_mem[e][exp_w.history] = c;
                if (exp_w.miss && miss_mem[e] != '1)
                    miss_mem[e] = miss_mem[e] + 1'b1;
                exp_w.total = miss_mem[e];
                hist_mem[e] = {exp_w.history[HIST_LEN-2:0], taken};
                next_entry = (e + 1 >= n_used) ? 0 : e + 1;
                predicted_words.insert(predicted_words.size(), exp_w);
            end

            if (cfg_we)
                entry_log2 = cfg_wdata;
        end
    end

endmodule

FILE: tb/sv/tb_local_history_branch_predictor.sv
`timescale 1ns / 1ps

module tb_local_history_branch_predictor;
    import lhbp_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 300;

    logic   clk;
    logic   rst_n;
    logic   cfg_we;
    cfg_t   cfg_wdata;
    logic   in_valid;
    logic   in_stall;
    logic   taken;
    logic   out_valid;
    logic   out_stall;
    entry_t entry_used;
    hist_t  history_used;
    logic   predicted_taken;
    logic   actual_taken;
    logic   missed;
    miss_t  miss_total;

    int fails;
    int checked;
    int sent;
    int cfg_writes;
    int cycle_count;
    bit tx_calm;
    bit rx_calm;
    bit hold_req;

    local_history_branch_predictor dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .taken           (taken),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .entry_used      (entry_used),
        .history_used    (history_used),
        .predicted_taken (predicted_taken),
        .actual_taken    (actual_taken),
        .missed          (missed),
        .miss_total      (miss_total)
    );

    branch_outcome_checker u_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .taken           (taken),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .entry_used      (entry_used),
        .history_used    (history_used),
        .predicted_taken (predicted_taken),
        .actual_taken    (actual_taken),
        .missed          (missed),
        .miss_total      (miss_total),
        .fails           (fails),
        .checked         (checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("%0t: timeout after %0d cycles, %0d of %0d words back",
                 $time, cycle_count, checked, sent);
        $display("[FAIL] regression broken");
        $finish;
    end

    // Offer one outcome word, returns at the edge where it was taken.
    task automatic push_word(input logic t);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, 17);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        taken    <= t;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sent++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (checked != sent)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_entries(input cfg_t v);
        wait_drained();
        cfg_wdata <= v;
        cfg_we    <= 1'b1;
        @(posedge clk);
        cfg_we    <= 1'b0;
        cfg_writes++;
    endtask

    // Result side: random stall per word, plus one long hold-off on request.
    initial
    begin
        int gap;
        bit held;
        held      = 1'b0;
        out_stall = 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_req && !held)
            begin
                held = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            gap = rx_calm ? 0 : $urandom_range(0, 17);
            if (gap > 0)
            begin
                out_stall <= 1'b1;
                repeat (gap) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    initial
    begin
        int         target;
        int         len;
        int         style;
        int         period;
        int         bias;
        int         phase;
        logic [7:0] pattern;
        logic       t;
        in_valid   = 1'b0;
        taken      = 1'b0;
        cfg_we     = 1'b0;
        cfg_wdata  = '0;
        rst_n      = 1'b0;
        tx_calm    = 1'b0;
        rx_calm    = 1'b0;
        hold_req   = 1'b0;
        sent       = 0;
        cfg_writes = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // one entry: drive a counter up to ST and hold, then down to SN and hold
        for (int k = 0; k < 14; k++)
            push_word(k < 7);
        // sixteen entries, leave pointer at 5, then shrink to two
        set_entries(cfg_t'(4));
        for (int k = 0; k < 5; k++)
            push_word(1'($urandom_range(0, 1)));
        set_entries(cfg_t'(1));
        for (int k = 0; k < 3; k++)
            push_word(1'($urandom_range(0, 1)));
        // out-of-range count saturates to sixteen
        set_entries(cfg_t'(7));
        for (int k = 0; k < 3; k++)
            push_word(1'($urandom_range(0, 1)));

        // back-pressure: result side frozen while input runs flat out
        set_entries(cfg_t'(4));
        hold_req = 1'b1;
        tx_calm  = 1'b1;
        for (int k = 0; k < 60; k++)
            push_word(1'($urandom_range(0, 1)));
        tx_calm = 1'b0;

        target = sent + 940;
        phase  = 0;
        while (sent < target)
        begin
            set_entries(cfg_t'($urandom_range(0, 7)));
            len     = (phase % 5 == 0) ? $urandom_range(1, 6) : $urandom_range(10, 60);
            tx_calm = ($urandom_range(0, 3) == 0);
            rx_calm = ($urandom_range(0, 3) == 0);
            style   = $urandom_range(0, 3);
            period  = $urandom_range(1, 8);
            pattern = 8'($urandom);
            bias    = $urandom_range(0, 10);
            for (int k = 0; k < len; k++)
            begin
                case (style)
                    0:       t = 1'($urandom_range(0, 1));
                    3:       t = ($urandom_range(0, 9) < bias);
                    default: t = pattern[k % period];
                endcase
                push_word(t);
            end
            phase++;
        end
        tx_calm = 1'b0;
        rx_calm = 1'b0;

        wait_drained();
        repeat (6) @(posedge clk);
        $display("Ran %0d branch outcomes over %0d entry-count writes, %0d results compared.",
                 sent, cfg_writes, checked);
        $display("Covered saturating counters, count shrink past pointer and a %0d-cycle hold.",
                 HOLD_CYCLES);
        if (fails == 0 && checked == sent)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
